// ----- hdl/rtc_register_bank_with_checksum_top_macros.svh -----
// ----------------------------------------------------------------------------
// rtc_register_bank_with_checksum_top_macros
// Assertion macros for the RTC register bank.
// ----------------------------------------------------------------------------
`ifndef RTC_REGISTER_BANK_WITH_CHECKSUM_TOP_MACROS_SVH
`define RTC_REGISTER_BANK_WITH_CHECKSUM_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RTCBANK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define RTCBANK_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `RTCBANK_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- hdl/rtcbank_pkg.sv -----
// ----------------------------------------------------------------------------
// rtcbank_pkg
// Shared constants, types and helpers of the RTC register bank.
// ----------------------------------------------------------------------------
package rtcbank_pkg;

  // Number of byte registers visible to a read transfer.
  localparam int RegCount = 40;
  // Bytes below this index live in the byte store; at and above it they are derived.
  localparam int StoreBytes = 32;
  localparam int StoreIdxW = $clog2(StoreBytes);

  // Commands
  localparam logic [2:0] CmdWrite  = 3'd0;
  localparam logic [2:0] CmdRead   = 3'd1;
  localparam logic [2:0] CmdSecond = 3'd2;
  localparam logic [2:0] CmdTick   = 3'd3;
  localparam logic [2:0] CmdDone   = 3'd4;

  // Port offsets
  localparam logic [2:0] PortMask   = 3'd0;
  localparam logic [2:0] PortStatus = 3'd2;
  localparam logic [2:0] PortAddr   = 3'd4;
  localparam logic [2:0] PortData   = 3'd6;

  // Byte indexes
  localparam logic [5:0] ChPowerOn = 6'd8;
  localparam logic [5:0] ChTick    = 6'd34;
  localparam logic [5:0] ChCheckHm = 6'd35;
  localparam logic [5:0] ChCheckL  = 6'd36;

  // Status bit positions
  localparam int StBusy   = 0;
  localparam int StDone   = 1;
  localparam int StSecond = 2;
  localparam logic [3:0] IrqBits = 4'he;

  localparam logic [7:0] PowerOnInit = 8'h10;
  localparam logic [9:0] SumInit     = 10'd1;
  localparam logic [2:0] TopReboot   = 3'b110;
  localparam logic [2:0] TopPowerOff = 3'b111;
  localparam logic [3:0] CheckLHigh  = 4'h2;
  localparam logic [15:0] ReadBadPort = 16'hffff;

  typedef struct packed {
    logic       wr;
    logic       tick;
    logic [5:0] ch;
    logic [7:0] wdata;
  } store_req_t;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       reboot;
    logic       poff;
  } store_rsp_t;

  function automatic logic [4:0] nib_sum(input logic [7:0] b);
    return {1'b0, b[3:0]} + {1'b0, b[7:4]};
  endfunction

  function automatic logic [7:0] byte_init(input logic [StoreIdxW-1:0] idx);
    return (idx == ChPowerOn[StoreIdxW-1:0]) ? PowerOnInit : 8'h00;
  endfunction

endpackage

// ----- hdl/rtcbank_store.sv -----
// ----------------------------------------------------------------------------
// rtcbank_store
// Byte registers 0..31, tick counter and running nibble sum with the
// derived checksum bytes 35 and 36.
// ----------------------------------------------------------------------------
module rtcbank_store import rtcbank_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output store_rsp_t rsp_o
);

  logic [7:0] bytes_q [StoreBytes];
  logic [7:0] tick_q;
  logic [9:0] sum_q, sum_d;
  logic [7:0] old_byte, new_byte;
  logic       in_store, summed, is_pon, we;
  logic       reboot, poff;

  assign old_byte = bytes_q[req_i.ch[StoreIdxW-1:0]];
  assign in_store = ({1'b0, req_i.ch} < 7'(StoreBytes));
  assign summed   = in_store && (req_i.ch >= ChPowerOn);
  assign is_pon   = (req_i.ch == ChPowerOn);
  assign we       = req_i.wr && in_store;

  always_comb begin
    new_byte = req_i.wdata;
    reboot   = 1'b0;
    poff     = 1'b0;
    if (is_pon) begin
      // keep the top bits unless a reboot code forces them
      new_byte = {old_byte[7:5], req_i.wdata[4:0]};
      if (req_i.wdata[7:5] == TopReboot) begin
        new_byte[7:5] = TopReboot;
        reboot = 1'b1;
      end else if (req_i.wdata[7:5] == TopPowerOff) begin
        poff = 1'b1;
      end
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (we && summed) begin
      sum_d = sum_q - 10'(nib_sum(old_byte)) + 10'(nib_sum(new_byte));
    end
  end

  always_comb begin
    rsp_o.reboot = we && is_pon && reboot;
    rsp_o.poff   = we && is_pon && poff;
    if (in_store) begin
      rsp_o.rd_byte = old_byte;
    end else begin
      case (req_i.ch)
        ChTick:    rsp_o.rd_byte = tick_q;
        ChCheckHm: rsp_o.rd_byte = {sum_q[5:2], sum_q[9:6]};
        ChCheckL:  rsp_o.rd_byte = {CheckLHigh, 2'b11, sum_q[1:0]};
        default:   rsp_o.rd_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreBytes; i++) begin
        bytes_q[i] <= byte_init(StoreIdxW'(i));
      end
      tick_q <= 8'h00;
      sum_q  <= SumInit;
    end else begin
      if (we) begin
        bytes_q[req_i.ch[StoreIdxW-1:0]] <= new_byte;
      end
      if (req_i.tick) begin
        tick_q <= tick_q + 8'd1;
      end
      sum_q <= sum_d;
    end
  end

endmodule

// ----- hdl/rtc_register_bank_with_checksum_top.sv -----
// ----------------------------------------------------------------------------
// rtc_register_bank_with_checksum_top
// RTC register bank with nibble checksum, driven by bus accesses and events.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------
//  input   | start, busy               | cmd_i, port_addr_i, bus_data_i
//  result  | result_valid_o (strobe)   | read_data_o, irq_o, reboot_request_o,
//          |                           | power_off_request_o
//
// One item per cycle; each result passes the input register, then the
// state update and result register.
// busy stays low: every item is processed in a single pass.
// Reset puts all registers at their initial values at once.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module rtc_register_bank_with_checksum_top import rtcbank_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  port_addr_i,
  input  logic [15:0] bus_data_i,
  output logic        result_valid_o,
  output logic [15:0] read_data_o,
  output logic        irq_o,
  output logic        reboot_request_o,
  output logic        power_off_request_o
);

  `include "rtc_register_bank_with_checksum_top_macros.svh"

  // input register
  logic        in_vld_q;
  logic [2:0]  cmd_q, port_q;
  logic [15:0] data_q;

  // block state
  logic [3:0] mask_q, mask_d;
  logic [3:0] status_q, status_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [7:0] in_byte_q, in_byte_d;

  // result register
  logic        res_vld_q;
  logic [15:0] rd_q, rd_d;
  logic        irq_q, reboot_q, poff_q;

  store_req_t store_req;
  store_rsp_t store_rsp;
  logic [5:0] ch;

  assign busy = 1'b0;
  assign ch   = addr_q[6:1];

  rtcbank_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rsp_o  (store_rsp)
  );

  // store write only for a pending, even, write transfer
  always_comb begin
    store_req.wr    = in_vld_q && (cmd_q == CmdDone) && status_q[StBusy] &&
                      !addr_q[0] && addr_q[7];
    store_req.tick  = in_vld_q && (cmd_q == CmdTick);
    store_req.ch    = ch;
    store_req.wdata = out_byte_q;
  end

  always_comb begin
    mask_d          = mask_q;
    status_d        = status_q;
    addr_d          = addr_q;
    out_byte_d      = out_byte_q;
    in_byte_d       = in_byte_q;
    rd_d            = 16'h0000;
    if (in_vld_q) begin
      case (cmd_q)
        CmdWrite: begin
          case (port_q)
            PortMask:   mask_d = data_q[3:0];
            PortStatus: status_d = status_q & ~(data_q[3:0] & IrqBits);
            PortAddr: begin
              // ignore a new address while a transfer is pending
              if (!status_q[StBusy]) begin
                addr_d           = data_q[7:0];
                status_d[StBusy] = 1'b1;
              end
            end
            PortData:   out_byte_d = data_q[7:0];
            default:    ;
          endcase
        end
        CmdRead: begin
          case (port_q)
            PortStatus: rd_d = {12'h000, status_q};
            PortData:   rd_d = {8'h00, in_byte_q};
            default:    rd_d = ReadBadPort;
          endcase
        end
        CmdSecond: status_d[StSecond] = 1'b1;
        CmdTick:   ;
        CmdDone: begin
          // drop a done event while no transfer is pending
          if (status_q[StBusy]) begin
            if (!addr_q[0] && !addr_q[7] && ({1'b0, ch} < 7'(RegCount))) begin
              in_byte_d = store_rsp.rd_byte;
            end
            status_d           = status_q & IrqBits;
            status_d[StDone]   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      cmd_q      <= CmdWrite;
      port_q     <= PortMask;
      data_q     <= 16'h0000;
      mask_q     <= 4'h0;
      status_q   <= 4'h0;
      addr_q     <= 8'h00;
      out_byte_q <= 8'h00;
      in_byte_q  <= 8'h00;
      res_vld_q  <= 1'b0;
      rd_q       <= 16'h0000;
      irq_q      <= 1'b0;
      reboot_q   <= 1'b0;
      poff_q     <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
      cmd_q    <= cmd_i;
      port_q   <= port_addr_i;
      data_q   <= bus_data_i;

      mask_q     <= mask_d;
      status_q   <= status_d;
      addr_q     <= addr_d;
      out_byte_q <= out_byte_d;
      in_byte_q  <= in_byte_d;

      res_vld_q <= in_vld_q;
      rd_q      <= rd_d;
      irq_q     <= |(mask_d & status_d & IrqBits);
      reboot_q  <= store_rsp.reboot;
      poff_q    <= store_rsp.poff;
    end
  end

  assign result_valid_o      = res_vld_q;
  assign read_data_o         = rd_q;
  assign irq_o               = irq_q;
  assign reboot_request_o    = reboot_q;
  assign power_off_request_o = poff_q;

  `RTCBANK_ASSERT(a_result_follows, clk_i, rst_ni, (start && !busy) |-> ##2 result_valid_o, "accepted item produced no result")
  `RTCBANK_ASSERT_NEVER(a_req_excl, clk_i, rst_ni, reboot_request_o && power_off_request_o, "reboot and power-off together")
  `RTCBANK_ASSERT_NEVER(a_req_strobe, clk_i, rst_ni, (reboot_request_o || power_off_request_o) && !result_valid_o, "request outside a result")
  `RTCBANK_ASSERT(a_done_clears_busy, clk_i, rst_ni, (in_vld_q && cmd_q == CmdDone && status_q[StBusy]) |=> (!status_q[StBusy] && status_q[StDone]), "done did not finish transfer")

endmodule

// ----- test/rtc_register_bank_with_checksum_checker.sv -----
// ----------------------------------------------------------------------------
// rtc_register_bank_with_checksum_checker
// Watches the command and result channels of the RTC register bank. Predicts
// each result from its own copy of the byte bank, status, mask and nibble sum,
// and compares every result field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rtc_register_bank_with_checksum_checker import rtcbank_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  port_addr_i,
  input  logic [15:0] bus_data_i,
  input  logic        result_valid_i,
  input  logic [15:0] read_data_i,
  input  logic        irq_i,
  input  logic        reboot_request_i,
  input  logic        power_off_request_i,
  output int          error_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          reboots_o,
  output int          power_offs_o,
  output int          irq_high_o
);

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq;
    logic        reboot;
    logic        poff;
  } bank_reply_t;

  bank_reply_t replies_due[$];

  logic [7:0] bank_bytes[RegCount];
  logic [3:0] irq_en;
  logic [3:0] status_r;
  logic [7:0] xfer_addr;
  logic [7:0] wr_byte;
  logic [7:0] rd_byte;
  logic [9:0] digit_sum;

  int errors;
  int due_cnt;
  int checked;
  int reboots;
  int power_offs;
  int irq_high;

  assign error_count_o = errors;
  assign pending_o     = due_cnt;
  assign checked_o     = checked;
  assign reboots_o     = reboots;
  assign power_offs_o  = power_offs;
  assign irq_high_o    = irq_high;

  // Store into the summed range and refresh both checksum bytes.
  function automatic void store_summed(input logic [5:0] idx, input logic [7:0] val);
    logic [7:0] old;
    old = bank_bytes[idx];
    digit_sum = digit_sum - 10'(old[3:0]) - 10'(old[7:4]) + 10'(val[3:0]) + 10'(val[7:4]);
    bank_bytes[idx] = val;
    bank_bytes[ChCheckHm] = {digit_sum[5:2], digit_sum[9:6]};
    bank_bytes[ChCheckL]  = {bank_bytes[ChCheckL][7:4], 2'b11, digit_sum[1:0]};
  endfunction

  function automatic bank_reply_t next_bank_reply(input logic [2:0] cmd,
                                                  input logic [2:0] port,
                                                  input logic [15:0] data);
    bank_reply_t r;
    logic [5:0]  ch;
    logic [7:0]  val;
    r  = '0;
    ch = xfer_addr[6:1];
    case (cmd)
      CmdWrite: begin
        case (port)
          PortMask:   irq_en = data[3:0];
          PortStatus: status_r = status_r & ~(data[3:0] & IrqBits);
          PortAddr: begin
            if (!status_r[StBusy]) begin
              xfer_addr = data[7:0];
              status_r[StBusy] = 1'b1;
            end
          end
          PortData:   wr_byte = data[7:0];
          default: ;
        endcase
      end
      CmdRead: begin
        case (port)
          PortStatus: r.read_data = {12'h000, status_r};
          PortData:   r.read_data = {8'h00, rd_byte};
          default:    r.read_data = ReadBadPort;
        endcase
      end
      CmdSecond: status_r[StSecond] = 1'b1;
      CmdTick:   bank_bytes[ChTick] = bank_bytes[ChTick] + 8'd1;
      CmdDone: begin
        if (status_r[StBusy]) begin
          if (xfer_addr[0]) begin
            // odd address: no transfer
          end else if (xfer_addr[7]) begin
            if (ch == ChPowerOn) begin
              val = {bank_bytes[ChPowerOn][7:5], wr_byte[4:0]};
              if (wr_byte[7:5] == TopReboot) begin
                val[7:5] = TopReboot;
                r.reboot = 1'b1;
              end else if (wr_byte[7:5] == TopPowerOff) begin
                r.poff = 1'b1;
              end
              store_summed(ch, val);
            end else if (ch < ChPowerOn) begin
              bank_bytes[ch] = wr_byte;
            end else if (ch < 6'd32) begin
              store_summed(ch, wr_byte);
            end
          end else if (ch < RegCount) begin
            rd_byte = bank_bytes[ch];
          end
          status_r[StBusy] = 1'b0;
          status_r[StDone] = 1'b1;
        end
      end
      default: ;
    endcase
    r.irq = |(irq_en & status_r & IrqBits);
    return r;
  endfunction

  function automatic void flag_error(input string what);
    if (errors < 10) $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bank_reply_t due;
    bank_reply_t seen;
    if (!rst_ni) begin
      foreach (bank_bytes[i]) bank_bytes[i] = 8'h00;
      bank_bytes[ChPowerOn] = PowerOnInit;
      bank_bytes[ChCheckL]  = {CheckLHigh, 4'hd};
      irq_en    = '0;
      status_r  = '0;
      xfer_addr = '0;
      wr_byte   = '0;
      rd_byte   = '0;
      digit_sum = SumInit;
      replies_due.delete();
      due_cnt   = 0;
    end else begin
      if (result_valid_i) begin
        seen = '{read_data_i, irq_i, reboot_request_i, power_off_request_i};
        if (replies_due.size() == 0) begin
          flag_error($sformatf("result with nothing pending: rd=%h irq=%b rb=%b po=%b",
                               seen.read_data, seen.irq, seen.reboot, seen.poff));
        end else begin
          due = replies_due.pop_front();
          if (due.read_data !== seen.read_data || due.irq !== seen.irq ||
              due.reboot !== seen.reboot || due.poff !== seen.poff)
            flag_error($sformatf("exp rd=%h irq=%b rb=%b po=%b, got rd=%h irq=%b rb=%b po=%b",
                                 due.read_data, due.irq, due.reboot, due.poff,
                                 seen.read_data, seen.irq, seen.reboot, seen.poff));
          checked++;
          if (due.reboot) reboots++;
          if (due.poff) power_offs++;
          if (due.irq) irq_high++;
        end
      end
      if (start_i && !busy_i)
        replies_due.push_back(next_bank_reply(cmd_i, port_addr_i, bus_data_i));
      due_cnt = replies_due.size();
    end
  end

endmodule

// ----- test/rtc_register_bank_with_checksum_top_tb.sv -----
// ----------------------------------------------------------------------------
// rtc_register_bank_with_checksum_top_tb
// Drives a directed set of bus accesses and events into the RTC register bank,
// then randomized transfer sequences mixed with noise, with random gaps outside one back-to-back stretch.
// A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rtc_register_bank_with_checksum_top_tb;
  import rtcbank_pkg::*;

  localparam int         TotalItems = 650;
  localparam int         CycleLimit = 200000;
  localparam logic [2:0] CmdSpareLo = 3'd5;
  localparam logic [2:0] CmdSpareHi = 3'd7;
  localparam logic [2:0] PortOddLo  = 3'd1;
  localparam logic [2:0] PortOddHi  = 3'd7;
  localparam logic [5:0] ChLast     = 6'd63;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  cmd_i;
  logic [2:0]  port_addr_i;
  logic [15:0] bus_data_i;
  logic        result_valid_o;
  logic [15:0] read_data_o;
  logic        irq_o;
  logic        reboot_request_o;
  logic        power_off_request_o;

  int errors, pending, checked, reboots, power_offs, irq_high;
  int cycles = 0;
  int n_sent = 0;
  int n_transfers = 0;
  bit idle_en = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rtc_register_bank_with_checksum_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cmd_i              (cmd_i),
    .port_addr_i        (port_addr_i),
    .bus_data_i         (bus_data_i),
    .result_valid_o     (result_valid_o),
    .read_data_o        (read_data_o),
    .irq_o              (irq_o),
    .reboot_request_o   (reboot_request_o),
    .power_off_request_o(power_off_request_o)
  );

  rtc_register_bank_with_checksum_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .cmd_i              (cmd_i),
    .port_addr_i        (port_addr_i),
    .bus_data_i         (bus_data_i),
    .result_valid_i     (result_valid_o),
    .read_data_i        (read_data_o),
    .irq_i              (irq_o),
    .reboot_request_i   (reboot_request_o),
    .power_off_request_i(power_off_request_o),
    .error_count_o      (errors),
    .pending_o          (pending),
    .checked_o          (checked),
    .reboots_o          (reboots),
    .power_offs_o       (power_offs),
    .irq_high_o         (irq_high)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] addr_byte(input logic wr, input logic [5:0] ch);
    return {wr, ch, 1'b0};
  endfunction

  // Hold start until the item is taken; insert random idle cycles first.
  task automatic issue_item(input logic [2:0] cmd, input logic [2:0] port,
                            input logic [15:0] data);
    if (idle_en) begin
      while ($urandom_range(99) < 29) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start       <= 1'b1;
    cmd_i       <= cmd;
    port_addr_i <= port;
    bus_data_i  <= data;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_sent++;
  endtask

  // Drop start and hold off until every pending result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Latch a transfer, optionally with events in between, then mostly complete it.
  task automatic run_transfer();
    logic       wr;
    logic [5:0] ch;
    logic [7:0] ob;
    int         pick;
    pick = $urandom_range(99);
    wr   = 1'($urandom_range(1));
    if (pick < 12)      ch = ChPowerOn;
    else if (pick < 85) ch = 6'($urandom_range(RegCount - 1));
    else                ch = 6'($urandom_range(63));
    ob = 8'($urandom);
    if (ch == ChPowerOn && $urandom_range(1))
      ob[7:5] = $urandom_range(1) ? TopReboot : TopPowerOff;
    if (wr) issue_item(CmdWrite, PortData, {8'($urandom), ob});
    issue_item(CmdWrite, PortAddr,
               {8'($urandom), addr_byte(wr, ch) | 8'($urandom_range(9) == 0)});
    repeat ($urandom_range(2)) issue_item(3'($urandom_range(3, 1)), 3'($urandom), 16'($urandom));
    if ($urandom_range(19) != 0) begin
      issue_item(CmdDone, 3'($urandom), 16'($urandom));
      n_transfers++;
    end
    if (!wr) issue_item(CmdRead, PortData, 16'($urandom));
    if ($urandom_range(3) == 0) issue_item(CmdRead, PortStatus, 16'($urandom));
    if ($urandom_range(2) == 0) issue_item(CmdWrite, PortStatus, 16'($urandom));
  endtask

  initial begin
    int  pick;
    bit  drained;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = CmdWrite;
    port_addr_i = PortMask;
    bus_data_i  = '0;
    drained     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ports, status bits, power-on byte, checksum and range corners
    issue_item(CmdRead,   PortStatus, 16'h0000);
    issue_item(CmdWrite,  PortMask,   16'hffff);
    issue_item(CmdSecond, PortMask,   16'h0000);
    issue_item(CmdRead,   PortStatus, 16'hffff);
    issue_item(CmdWrite,  PortStatus, 16'hffff);
    issue_item(CmdDone,   PortMask,   16'h0000);
    issue_item(CmdWrite,  PortData,   16'h00c5);
    issue_item(CmdWrite,  PortAddr,   {8'h00, addr_byte(1'b1, ChPowerOn)});
    issue_item(CmdWrite,  PortAddr,   {8'hff, addr_byte(1'b0, 6'd0)});
    issue_item(CmdDone,   PortData,   16'hffff);
    issue_item(CmdWrite,  PortData,   16'hffff);
    issue_item(CmdWrite,  PortAddr,   {8'hff, addr_byte(1'b1, ChPowerOn)});
    issue_item(CmdDone,   PortMask,   16'h0000);
    issue_item(CmdWrite,  PortAddr,   {8'h00, addr_byte(1'b0, ChCheckHm)});
    issue_item(CmdDone,   PortMask,   16'h0000);
    issue_item(CmdRead,   PortData,   16'h0000);
    issue_item(CmdTick,   PortMask,   16'h0000);
    issue_item(CmdWrite,  PortAddr,   {8'h00, addr_byte(1'b0, ChTick)});
    issue_item(CmdDone,   PortMask,   16'h0000);
    issue_item(CmdRead,   PortData,   16'h0000);
    issue_item(CmdWrite,  PortAddr,   {8'h00, addr_byte(1'b1, 6'd0) | 8'h01});
    issue_item(CmdDone,   PortMask,   16'h0000);
    issue_item(CmdWrite,  PortAddr,   {8'h00, addr_byte(1'b1, ChLast)});
    issue_item(CmdDone,   PortMask,   16'h0000);
    issue_item(CmdWrite,  PortAddr,   {8'h00, addr_byte(1'b0, ChLast)});
    issue_item(CmdDone,   PortMask,   16'h0000);
    issue_item(CmdRead,   PortData,   16'h0000);
    issue_item(CmdSpareLo, PortAddr,  16'hffff);
    issue_item(CmdSpareHi, PortData,  16'hffff);
    issue_item(CmdRead,   PortOddHi,  16'h0000);
    issue_item(CmdWrite,  PortOddLo,  16'hffff);
    issue_item(CmdWrite,  PortMask,   16'h0000);
    drain();

    // random: mostly well-formed transfers, some control and raw noise
    while (n_sent < TotalItems) begin
      idle_en = !(n_sent >= 250 && n_sent < 400);
      if (!drained && n_sent >= 340) begin
        drain();
        drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        run_transfer();
      end else if (pick < 75) begin
        case ($urandom_range(2))
          0:       issue_item(CmdWrite, PortMask, 16'($urandom));
          1:       issue_item(CmdSecond, 3'($urandom), 16'($urandom));
          default: repeat ($urandom_range(1, 8)) issue_item(CmdTick, 3'($urandom), 16'($urandom));
        endcase
      end else begin
        issue_item(3'($urandom), 3'($urandom), 16'($urandom));
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    $display("Run: %0d items sent, %0d results checked, %0d transfers completed",
             n_sent, checked, n_transfers);
    $display("Run: %0d reboot and %0d power-off pulses, %0d results with irq high",
             reboots, power_offs, irq_high);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- rtc_register_bank_with_checksum_top.f -----
+incdir+hdl
hdl/rtcbank_pkg.sv
hdl/rtcbank_store.sv
hdl/rtc_register_bank_with_checksum_top.sv
test/rtc_register_bank_with_checksum_checker.sv
test/rtc_register_bank_with_checksum_top_tb.sv
